// ----- src/cbrg_pkg.sv -----
`timescale 1ns / 1ps

package cbrg_pkg;

    localparam int MAX_BURST   = 64;
    localparam int KEY_WORDS   = 6;
    localparam int LANE_W      = 32;
    localparam int INDEX_W     = 64;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = $clog2(KEY_WORDS);
    localparam int MIX_STEPS   = 9;
    localparam int STEP_W      = $clog2(MIX_STEPS);

    typedef struct packed {
        logic [INDEX_W-1:0] start_index;
        logic [COUNT_W-1:0] count;
    } t_in_word;

    typedef struct packed {
        logic [LANE_W-1:0] random_word;
        logic              last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MIX,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic mix;
        logic put;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_zero;
        logic step_done;
        logic burst_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [LANE_W-1:0] rot_step(input logic [LANE_W-1:0] x,
                                                   input logic [STEP_W-1:0] step);
        logic [LANE_W-1:0] r;
        case (step)
            4'd0:    r = (x << 7)  | (x >> 25);
            4'd1:    r = (x << 9)  | (x >> 23);
            4'd2:    r = (x << 13) | (x >> 19);
            4'd3:    r = (x << 18) | (x >> 14);
            4'd4:    r = (x << 7)  | (x >> 25);
            4'd5:    r = (x << 9)  | (x >> 23);
            4'd6:    r = (x << 13) | (x >> 19);
            4'd7:    r = (x << 18) | (x >> 14);
            4'd8:    r = (x << 12) | (x >> 20);
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic logic sub_step(input logic [STEP_W-1:0] step);
        logic s;
        case (step)
            4'd0:    s = 1'b1;
            4'd4:    s = 1'b1;
            4'd8:    s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// ----- src/cbrg_ctrl.sv -----
`timescale 1ns / 1ps

module cbrg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  cbrg_pkg::t_dp_status  i_status,
    output cbrg_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_in_stall
);

    cbrg_pkg::t_state r_state;
    cbrg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbrg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cbrg_pkg::ST_IDLE: begin
                if (i_in_valid && !i_status.in_zero) begin
                    n_state = cbrg_pkg::ST_LOAD;
                end
            end
            cbrg_pkg::ST_LOAD: begin
                n_state = cbrg_pkg::ST_MIX;
            end
            cbrg_pkg::ST_MIX: begin
                if (i_status.step_done) begin
                    n_state = cbrg_pkg::ST_PUT;
                end
            end
            cbrg_pkg::ST_PUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.burst_done ? cbrg_pkg::ST_IDLE : cbrg_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = cbrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            cbrg_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            cbrg_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            cbrg_pkg::ST_MIX: begin
                o_cmd.mix = 1'b1;
            end
            cbrg_pkg::ST_PUT: begin
                o_cmd.put = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- src/cbrg_datapath.sv -----
`timescale 1ns / 1ps

module cbrg_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cbrg_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [cbrg_pkg::LANE_W-1:0]          i_cfg_data,
    input  cbrg_pkg::t_in_word                   i_in_word,
    input  logic                                 i_out_stall,
    input  cbrg_pkg::t_ctrl_cmd                  i_cmd,
    output cbrg_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    output cbrg_pkg::t_out_word                  o_out_word
);

    logic [cbrg_pkg::LANE_W-1:0]  r_key  [cbrg_pkg::KEY_WORDS];
    logic [cbrg_pkg::LANE_W-1:0]  r_lane [cbrg_pkg::KEY_WORDS];
    logic [cbrg_pkg::INDEX_W-1:0] r_index;
    logic [cbrg_pkg::COUNT_W-1:0] r_remaining;
    logic [cbrg_pkg::STEP_W-1:0]  r_step;
    logic                         r_out_valid;
    cbrg_pkg::t_out_word          r_out;

    logic [cbrg_pkg::COUNT_W-1:0] sat_count;
    logic [cbrg_pkg::LANE_W-1:0]  mix_x;
    logic [cbrg_pkg::LANE_W-1:0]  mix_y;
    logic [cbrg_pkg::LANE_W-1:0]  mix_z;
    logic [cbrg_pkg::LANE_W-1:0]  idx_lo;
    logic [cbrg_pkg::LANE_W-1:0]  idx_hi;
    logic                         out_free;

    assign idx_lo = r_index[cbrg_pkg::LANE_W-1:0];
    assign idx_hi = r_index[cbrg_pkg::INDEX_W-1:cbrg_pkg::LANE_W];

    assign sat_count = (i_in_word.count > cbrg_pkg::COUNT_W'(cbrg_pkg::MAX_BURST))
                       ? cbrg_pkg::COUNT_W'(cbrg_pkg::MAX_BURST) : i_in_word.count;

    assign mix_x = cbrg_pkg::rot_step(r_lane[0], r_step);
    assign mix_y = cbrg_pkg::sub_step(r_step) ? (r_lane[1] - mix_x) : (r_lane[1] + mix_x);
    assign mix_z = r_lane[2] ^ mix_y;

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.in_zero    = (i_in_word.count == '0);
    assign o_status.step_done  = (r_step == cbrg_pkg::STEP_W'(cbrg_pkg::MIX_STEPS - 1));
    assign o_status.burst_done = (r_remaining == cbrg_pkg::COUNT_W'(1));
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cbrg_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < cbrg_pkg::KEY_WORDS; i++) begin
                if (i_cfg_index == cbrg_pkg::CFG_INDEX_W'(i)) begin
                    r_key[i] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_remaining <= '0;
            r_step      <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_index     <= i_in_word.start_index;
                r_remaining <= sat_count;
            end else if (i_cmd.put) begin
                r_index     <= r_index + cbrg_pkg::INDEX_W'(1);
                r_remaining <= r_remaining - cbrg_pkg::COUNT_W'(1);
            end
            if (i_cmd.load) begin
                r_step <= '0;
            end else if (i_cmd.mix) begin
                r_step <= r_step + cbrg_pkg::STEP_W'(1);
            end
        end
    end

    // Lanes rotate down by two each step so the working lanes are always 0..2.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lane[0] <= r_key[0] + idx_lo;
            r_lane[1] <= r_key[1] ^ idx_lo;
            r_lane[2] <= r_key[2] + idx_hi;
            r_lane[3] <= r_key[3] ^ idx_hi;
            r_lane[4] <= r_key[4];
            r_lane[5] <= r_key[5];
        end else if (i_cmd.mix) begin
            r_lane[0] <= mix_z;
            r_lane[1] <= r_lane[3];
            r_lane[2] <= r_lane[4];
            r_lane[3] <= r_lane[5];
            r_lane[4] <= mix_x;
            r_lane[5] <= mix_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out.random_word <= r_lane[0] ^ r_lane[3];
            r_out.last        <= o_status.burst_done;
        end
    end

endmodule

// ----- src/counter_based_random_generator.sv -----
`timescale 1ns / 1ps
// Counter-based random generator.
// Key: six 32-bit registers the user writes via i_cfg_we/i_cfg_index/i_cfg_data
// only while the block is idle (unenforced); indexes past the key are dropped.
// Input channel (i_in_valid, o_in_stall, i_in_word): one word carries a 64-bit
// start index and a count; counts above 64 are clipped to 64, zero gives nothing.
// Output channel (o_out_valid, i_out_stall, o_out_word): one 32-bit word per
// index, counting up with wrap at 2^64; last marks the final word of a burst.
// Each word goes through one lane load, nine mixing steps through a single
// shared step unit and one output write; the block takes no new input word
// until the last word of its burst is written to the output register.
// A finished word sits in the output register while the next one is mixed;
// if the receiver stalls, the generator waits with the next word and holds.
// Reset (synchronous, active low) clears the key, the burst state and the
// output valid; the block then takes input words at once.
module counter_based_random_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbrg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [cbrg_pkg::LANE_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cbrg_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cbrg_pkg::t_out_word               o_out_word
);

    cbrg_pkg::t_ctrl_cmd  cmd;
    cbrg_pkg::t_dp_status status;

    cbrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    cbrg_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- src/cbrg_checker.sv -----
`timescale 1ns / 1ps

module cbrg_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input cbrg_pkg::t_in_word   i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input cbrg_pkg::t_out_word  o_out_word
);

    a_busy_after_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_word.count != '0)) |=> o_in_stall)
        else $error("burst started but input not stalled");

    a_mid_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_word.last) |-> o_in_stall)
        else $error("input open while burst unfinished");

    a_idle_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_stall) |-> o_out_word.last)
        else $error("idle with a non-final word pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

endmodule

bind counter_based_random_generator cbrg_checker u_cbrg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ----- tb/counter_based_random_generator_test.sv -----
`timescale 1ns / 1ps

module counter_based_random_generator_test;

    import cbrg_pkg::*;

    localparam int CYCLE_LIMIT      = 10_000_000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int HOLD_OFF_LEN     = 400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY0,
        REG_KEY1,
        REG_KEY2,
        REG_KEY3,
        REG_KEY4,
        REG_KEY5,
        REG_SPARE6,
        REG_SPARE7
    } t_cfg_reg;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [LANE_W-1:0]      i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_word               i_in_word;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_word              o_out_word;

    logic [LANE_W-1:0] key_lane [KEY_WORDS];
    t_out_word         expected_words [$];
    int                errors;
    int                cycle_count;
    int                hold_off_cycles;
    bit                calm_traffic;

    counter_based_random_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] keyed_word(input logic [63:0] idx);
        logic [31:0] w [6];
        for (int i = 0; i < KEY_WORDS; i++) w[i] = key_lane[i];
        w[0] += idx[31:0];
        w[1] ^= idx[31:0];
        w[2] += idx[63:32];
        w[3] ^= idx[63:32];

        w[0] = rotl32(w[0], 7);
        w[1] -= w[0];
        w[2] ^= w[1];
        w[2] = rotl32(w[2], 9);
        w[3] += w[2];
        w[4] ^= w[3];
        w[4] = rotl32(w[4], 13);
        w[5] += w[4];
        w[0] ^= w[5];

        w[0] = rotl32(w[0], 18);
        w[1] += w[0];
        w[2] ^= w[1];
        w[2] = rotl32(w[2], 7);
        w[3] -= w[2];
        w[4] ^= w[3];
        w[4] = rotl32(w[4], 9);
        w[5] += w[4];
        w[0] ^= w[5];

        w[0] = rotl32(w[0], 13);
        w[1] += w[0];
        w[2] ^= w[1];
        w[2] = rotl32(w[2], 18);
        w[3] += w[2];
        w[4] ^= w[3];
        w[4] = rotl32(w[4], 12);
        w[5] -= w[4];
        w[0] ^= w[5];
        return w[0] ^ w[3];
    endfunction

    function automatic void queue_burst_words(input logic [63:0] start,
                                              input logic [COUNT_W-1:0] count);
        int        n;
        logic [63:0] idx;
        t_out_word exp;
        n = (count > MAX_BURST) ? MAX_BURST : int'(count);
        idx = start;
        for (int k = 0; k < n; k++) begin
            exp.random_word = keyed_word(idx);
            exp.last = (k + 1 == n);
            expected_words.push_back(exp);
            idx = idx + 64'd1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_traffic) return 0;
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 70) return COUNT_W'($urandom_range(1, 8));
        if (r < 85) return COUNT_W'($urandom_range(9, 32));
        if (r < 93) return COUNT_W'($urandom_range(33, MAX_BURST));
        return COUNT_W'($urandom_range(MAX_BURST + 1, 127));
    endfunction

    function automatic logic [63:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return {$urandom, $urandom};
        if (r < 80) return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
        if (r < 90) return {$urandom, 32'hFFFF_FFF0 + 32'($urandom_range(0, 15))};
        return 64'($urandom_range(0, 100));
    endfunction

    initial begin : out_stall_driver
        int stall_left;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_stall = 1'b1;
                hold_off_cycles--;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
                if (!calm_traffic && $urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    initial begin : result_checker
        t_out_word exp;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got word %h last %b",
                             $time, o_out_word.random_word, o_out_word.last);
                    errors++;
                end else begin
                    exp = expected_words.pop_front();
                    if (o_out_word.random_word !== exp.random_word) begin
                        $display("%0t: random_word mismatch, expected %h, got %h",
                                 $time, exp.random_word, o_out_word.random_word);
                        errors++;
                    end
                    if (o_out_word.last !== exp.last) begin
                        $display("%0t: last mismatch, expected %b, got %b",
                                 $time, exp.last, o_out_word.last);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : cycle_watchdog
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d words outstanding",
                         $time, expected_words.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_key(input t_cfg_reg reg_idx, input logic [LANE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = reg_idx;
        i_cfg_data = data;
        if (reg_idx <= REG_KEY5) key_lane[reg_idx] = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all_keys(input logic [LANE_W-1:0] data);
        for (int i = 0; i < KEY_WORDS; i++) write_key(t_cfg_reg'(i), data);
    endtask

    task automatic offer_burst(input logic [63:0] start, input logic [COUNT_W-1:0] count);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_word.start_index = start;
        i_in_word.count = count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        queue_burst_words(start, count);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (expected_words.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_key_corners();
        offer_burst(64'd0, 7'd1);
        offer_burst(64'd0, 7'd0);
        sender_gap(pick_gap());
        offer_burst(64'hFFFF_FFFF_FFFF_FFFF, 7'd3);
        offer_burst(64'h0000_0000_FFFF_FFFE, 7'd4);
        sender_gap(pick_gap());
        offer_burst(64'h5555_5555_5555_5555, 7'd64);
        offer_burst(64'hAAAA_AAAA_AAAA_AAAA, 7'd65);
        offer_burst({$urandom, $urandom}, 7'd127);
        offer_burst(64'h8000_0000_0000_0000, 7'd1);
        offer_burst(64'h7FFF_FFFF_FFFF_FFFF, 7'd2);
        drain_results();
    endtask

    task automatic test_key_registers();
        write_all_keys(32'hFFFF_FFFF);
        offer_burst(64'd0, 7'd1);
        offer_burst(64'hFFFF_FFFF_FFFF_FFFF, 7'd2);
        drain_results();
        write_key(REG_SPARE6, 32'h0000_0000);
        write_key(REG_SPARE7, 32'h1234_5678);
        offer_burst(64'd1, 7'd3);
        drain_results();
        write_key(REG_KEY0, 32'hAAAA_AAAA);
        write_key(REG_KEY1, 32'h5555_5555);
        write_key(REG_KEY2, 32'hAAAA_AAAA);
        write_key(REG_KEY3, 32'h5555_5555);
        write_key(REG_KEY4, 32'hAAAA_AAAA);
        write_key(REG_KEY5, 32'h5555_5555);
        offer_burst(64'd123, 7'd5);
        offer_burst(64'hFFFF_FFFF_0000_0000, 7'd0);
        offer_burst(64'h0000_0001_0000_0000, 7'd2);
        drain_results();
    endtask

    task automatic test_random_bursts();
        for (int phase = 0; phase < 4; phase++) begin
            for (int i = 0; i < KEY_WORDS; i++)
                write_key(t_cfg_reg'(i), (phase == 0) ? 32'h0 : $urandom);
            calm_traffic = (phase == 2);
            repeat (RANDOM_PER_PHASE) begin
                offer_burst(pick_index(), pick_count());
                sender_gap(pick_gap());
            end
            drain_results();
            calm_traffic = 1'b0;
        end
    endtask

    task automatic test_output_hold_off();
        for (int i = 0; i < KEY_WORDS; i++) write_key(t_cfg_reg'(i), $urandom);
        @(negedge i_clk);
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (6) offer_burst(pick_index(), 7'd4);
        drain_results();
    endtask

    initial begin : stimulus
        errors = 0;
        hold_off_cycles = 0;
        calm_traffic = 1'b0;
        for (int i = 0; i < KEY_WORDS; i++) key_lane[i] = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key_corners();
        test_key_registers();
        test_random_bursts();
        test_output_hold_off();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
